// ===== rtl/core/mhw_pkg.sv =====
`timescale 1ns / 1ps

package mhw_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W     = 4;
	localparam int CNT_W    = 5;
	localparam int OP_W     = 3;
	localparam int ST_W     = 3;
	localparam int TIME_W   = 32;
	localparam int GRACE_W  = 16;
	localparam int MISS_W   = 8;
	localparam int MAXA_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_KICK   = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
	localparam logic [OP_W-1:0] OP_RESUME = 3'd3;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
	localparam logic [ST_W-1:0] ST_TIMEOUT   = 3'd3;
	localparam logic [ST_W-1:0] ST_DEAD      = 3'd4;
	localparam logic [ST_W-1:0] ST_SCAN_DONE = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_GRACE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACTIVE = 2'd3;

	localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd10;
	localparam logic [MISS_W-1:0]  MISS_RESET  = 8'd3;
	localparam logic [TIME_W-1:0]  JUMP_RESET  = 32'd60;
	localparam logic [MAXA_W-1:0]  MAXA_RESET  = 5'd16;

	localparam logic [MISS_W-1:0]  MISS_SAT    = 8'hFF;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} chk_ctl_t;

endpackage

// ===== rtl/core/mhw_cmd_if.sv =====
`timescale 1ns / 1ps

interface mhw_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [mhw_pkg::OP_W-1:0]   op;
	logic [mhw_pkg::CH_W-1:0]   channel;
	logic [mhw_pkg::TIME_W-1:0] timeout_period;
	logic [mhw_pkg::TIME_W-1:0] now;
	logic [15:0]                alive_mask;

	modport source (output valid, op, channel, timeout_period, now, alive_mask, input ready);
	modport sink (input valid, op, channel, timeout_period, now, alive_mask, output ready);
endinterface

// ===== rtl/core/mhw_rsp_if.sv =====
`timescale 1ns / 1ps

interface mhw_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [mhw_pkg::ST_W-1:0] status;
	logic [mhw_pkg::CH_W-1:0] channel_res;
	logic                     last;

	modport source (output valid, status, channel_res, last, input ready);
	modport sink (input valid, status, channel_res, last, output ready);
endinterface

// ===== rtl/core/mhw_elapsed_unit.sv =====
`timescale 1ns / 1ps

module mhw_elapsed_unit (
	input  logic                          clk,
	input  mhw_pkg::chk_ctl_t             ctl,
	input  logic [mhw_pkg::TIME_W-1:0]    now,
	input  logic [mhw_pkg::TIME_W-1:0]    stamp,
	input  logic [mhw_pkg::TIME_W-1:0]    period,
	input  logic [mhw_pkg::GRACE_W-1:0]   grace,
	output logic                          over
);
	import mhw_pkg::*;

	logic [TIME_W-1:0] diff_s1;
	logic [TIME_W:0]   lim_s1;
	logic [TIME_W-1:0] mag_s2;
	logic [TIME_W:0]   lim_s2;

	// difference and allowed time
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			diff_s1 <= now - stamp;
			lim_s1  <= {1'b0, period} + {{(TIME_W + 1 - GRACE_W){1'b0}}, grace};
		end
	end

	// magnitude of signed difference
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			mag_s2 <= diff_s1[TIME_W-1] ? (~diff_s1 + 1'b1) : diff_s1;
			lim_s2 <= lim_s1;
		end
	end

	assign over = {1'b0, mag_s2} > lim_s2;

endmodule

// ===== rtl/core/multi_channel_heartbeat_watchdog_top.sv =====
`timescale 1ns / 1ps

// channel | dir | payload                                            | handshake
// cmd     | in  | op, channel, timeout_period, now, alive_mask       | valid/ready
// rsp     | out | status, channel_res, last                          | valid/ready
// cfg     | in  | cfg_idx, cfg_data                                  | cfg_we, no wait
//
// Create, kick, stop and resume are executed in S_EXEC with one result.
// A tick scans all channels: a checked channel passes S_RD, S_ABS and S_CMP
// through the shared elapsed-time unit, a skipped or dead one only S_RD.
// cmd.ready is high only while no item is in progress; a stalled rsp
// holds the sequencer at the next report. arst_n clears all control state.

module multi_channel_heartbeat_watchdog_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mhw_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [mhw_pkg::CFG_DATA_W-1:0]   cfg_data,
	mhw_cmd_if.sink                          cmd,
	mhw_rsp_if.source                        rsp
);
	import mhw_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_ABS  = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

	logic [2:0]        state_q, state_d;
	logic [CH_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]  k_q, k_d;
	logic              jump_q;
	logic [TIME_W-1:0] ref_q;

	logic [GRACE_W-1:0] grace_q;
	logic [MISS_W-1:0]  miss_limit_q;
	logic [TIME_W-1:0]  jump_limit_q;
	logic [MAXA_W-1:0]  max_active_q;

	logic [CHANNELS-1:0] used_q;
	logic [CHANNELS-1:0] run_q;
	logic [TIME_W-1:0]   period_q [CHANNELS];
	logic [TIME_W-1:0]   kick_q [CHANNELS];
	logic [MISS_W-1:0]   miss_q [CHANNELS];

	logic [OP_W-1:0]   op_q;
	logic [CH_W-1:0]   chan_q;
	logic [TIME_W-1:0] tp_q;
	logic [TIME_W-1:0] now_q;
	logic [15:0]       mask_q;

	logic              out_vld_q;
	logic [ST_W-1:0]   out_st_q;
	logic [CH_W-1:0]   out_ch_q;
	logic              out_last_q;

	logic              accept;
	logic              out_free;
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  lim;
	logic [CH_W-1:0]   free_idx;
	logic              free_found;
	logic              full;
	logic              found;
	logic [TIME_W:0]   ref_diff;
	logic              jump;
	logic              rpt_ok;
	logic              over;
	logic              tmo;
	logic              emit;
	logic [ST_W-1:0]   e_st;
	logic [CH_W-1:0]   e_ch;
	logic              e_last;
	logic              cmd_commit;
	logic              dead_commit;
	logic              cmp_commit;
	chk_ctl_t          chk_ctl;

	assign accept   = cmd.valid && cmd.ready;
	assign out_free = !out_vld_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE);

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_st_q;
	assign rsp.channel_res = out_ch_q;
	assign rsp.last        = out_last_q;

	always_comb begin
		cnt        = '0;
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			cnt = cnt + CNT_W'(used_q[i]);
			if (!used_q[i]) begin
				free_idx   = CH_W'(i);
				free_found = 1'b1;
			end
		end
	end

	assign lim      = (max_active_q > MAXA_W'(CHANNELS)) ? CNT_W'(CHANNELS) : max_active_q;
	assign full     = (cnt >= lim) || !free_found;
	assign found    = used_q[chan_q];
	assign ref_diff = {1'b0, now_q} - {1'b0, ref_q};
	assign jump     = ref_diff[TIME_W] || (ref_diff[TIME_W-1:0] > jump_limit_q);
	assign rpt_ok   = !k_q[CNT_W-1];
	assign tmo      = over && (miss_q[idx_q] > miss_limit_q);

	assign chk_ctl.ld_s1 = (state_q == S_RD);
	assign chk_ctl.ld_s2 = (state_q == S_ABS);

	mhw_elapsed_unit u_elapsed (
		.clk    (clk),
		.ctl    (chk_ctl),
		.now    (now_q),
		.stamp  (jump_q ? now_q : kick_q[idx_q]),
		.period (period_q[idx_q]),
		.grace  (grace_q),
		.over   (over)
	);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		k_d         = k_q;
		emit        = 1'b0;
		e_st        = ST_OK;
		e_ch        = '0;
		e_last      = 1'b0;
		cmd_commit  = 1'b0;
		dead_commit = 1'b0;
		cmp_commit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_TICK) begin
					idx_d   = '0;
					k_d     = '0;
					state_d = S_RD;
				end else if (op_q > OP_RESUME) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					cmd_commit = 1'b1;
					emit       = 1'b1;
					e_last     = 1'b1;
					state_d    = S_IDLE;
					if (op_q == OP_CREATE) begin
						e_st = full ? ST_FULL : ST_OK;
						e_ch = full ? '0 : free_idx;
					end else begin
						e_st = found ? ST_OK : ST_NOT_FOUND;
						e_ch = chan_q;
					end
				end
			end
			S_RD: begin
				if (!used_q[idx_q] || run_q[idx_q]) begin
					state_d = (idx_q == LAST_IDX) ? S_DONE : S_RD;
					idx_d   = idx_q + 1'b1;
				end else if (!mask_q[idx_q]) begin
					if (!rpt_ok || out_free) begin
						dead_commit = 1'b1;
						if (rpt_ok) begin
							emit = 1'b1;
							e_st = ST_DEAD;
							e_ch = idx_q;
							k_d  = k_q + 1'b1;
						end
						state_d = (idx_q == LAST_IDX) ? S_DONE : S_RD;
						idx_d   = idx_q + 1'b1;
					end
				end else begin
					state_d = S_ABS;
				end
			end
			S_ABS: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!(tmo && rpt_ok) || out_free) begin
					cmp_commit = 1'b1;
					if (tmo && rpt_ok) begin
						emit = 1'b1;
						e_st = ST_TIMEOUT;
						e_ch = idx_q;
						k_d  = k_q + 1'b1;
					end
					state_d = (idx_q == LAST_IDX) ? S_DONE : S_RD;
					idx_d   = idx_q + 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_st    = ST_SCAN_DONE;
					e_last  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			k_q          <= '0;
			jump_q       <= 1'b0;
			ref_q        <= '0;
			used_q       <= '0;
			run_q        <= '0;
			out_vld_q    <= 1'b0;
			grace_q      <= GRACE_RESET;
			miss_limit_q <= MISS_RESET;
			jump_limit_q <= JUMP_RESET;
			max_active_q <= MAXA_RESET;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			k_q     <= k_d;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_GRACE:      grace_q      <= cfg_data[GRACE_W-1:0];
					CFG_MISS:       miss_limit_q <= cfg_data[MISS_W-1:0];
					CFG_JUMP:       jump_limit_q <= cfg_data[TIME_W-1:0];
					CFG_MAX_ACTIVE: max_active_q <= cfg_data[MAXA_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_EXEC && op_q == OP_TICK) begin
				jump_q <= jump;
				ref_q  <= now_q;
			end
			if (cmd_commit) begin
				case (op_q)
					OP_CREATE: begin
						if (!full) begin
							used_q[free_idx] <= 1'b1;
							run_q[free_idx]  <= 1'b0;
						end
					end
					OP_STOP:   if (found) run_q[chan_q] <= 1'b1;
					OP_RESUME: if (found) run_q[chan_q] <= 1'b0;
					default: ;
				endcase
			end
			if (dead_commit) begin
				used_q[idx_q] <= 1'b0;
				run_q[idx_q]  <= 1'b0;
			end
			if (emit)
				out_vld_q <= 1'b1;
			else if (rsp.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= cmd.op;
			chan_q <= cmd.channel;
			tp_q   <= cmd.timeout_period;
			now_q  <= cmd.now;
			mask_q <= cmd.alive_mask;
		end
		if (emit) begin
			out_st_q   <= e_st;
			out_ch_q   <= e_ch;
			out_last_q <= e_last;
		end
		if (cmd_commit && op_q == OP_CREATE && !full) begin
			period_q[free_idx] <= tp_q;
			kick_q[free_idx]   <= now_q;
			miss_q[free_idx]   <= '0;
		end
		if (cmd_commit && op_q == OP_KICK && found)
			kick_q[chan_q] <= now_q;
		// restamp every allocated channel after a time jump
		if (state_q == S_RD && jump_q && used_q[idx_q])
			kick_q[idx_q] <= now_q;
		if (cmp_commit) begin
			if (over)
				miss_q[idx_q] <= (miss_q[idx_q] != MISS_SAT) ? miss_q[idx_q] + 1'b1
					: miss_q[idx_q];
			else
				miss_q[idx_q] <= '0;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted item not executed");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> idx_q == '0)
		else $error("scan index not cleared at idle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) && out_last_q |-> state_q == S_IDLE)
		else $error("final result while busy");

	a_report_cap: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= CNT_W'(16))
		else $error("report count overflow");

endmodule
